@@ design/skvt_pkg.sv @@
// skvt_pkg: shared constants, codes and control types of the sorted key/value table
// used by the channel interfaces, the controller, the datapath and the top level
package skvt_pkg;

  localparam int DEPTH      = 16;
  localparam int KEY_BITS   = 32;
  localparam int DATUM_BITS = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int ENTRY_W    = KEY_BITS + DATUM_BITS;

  // request kinds; the two unused codes fall to default arms
  typedef enum logic [2:0] {
    REQ_INSERT = 3'd0,
    REQ_REMOVE = 3'd1,
    REQ_FIND   = 3'd2,
    REQ_FIRST  = 3'd3,
    REQ_STEP   = 3'd4,
    REQ_CLEAR  = 3'd5
  } req_type_t;

  // reply status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_FOUND  = 2'd1,
    ST_FULL       = 2'd2,
    ST_CURSOR_OFF = 2'd3
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_WRITE,
    S_UPDATE,
    S_FETCH,
    S_LOAD
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic in_ready;
    logic load_req;
    logic scan;
    logic shift_up;
    logic shift_dn;
    logic write_new;
    logic update;
    logic fetch;
    logic load_out;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic scan_done;
    logic shift_done;
    logic is_insert;
    logic is_remove;
    logic hit;
    logic full;
    logic out_free;
  } stat_t;

endpackage

@@ design/skvt_if.sv @@
// skvt_if: valid/ready channel interfaces for requests and replies
// depends on skvt_pkg for field widths
interface skvt_in_if;
  logic                                     valid;
  logic                                     ready;
  logic [2:0]                               req_type;
  logic signed [skvt_pkg::KEY_BITS-1:0]     req_key;
  logic [skvt_pkg::DATUM_BITS-1:0]          req_datum;

  modport source (output valid, output req_type, output req_key, output req_datum,
                  input ready);
  modport sink   (input valid, input req_type, input req_key, input req_datum,
                  output ready);
endinterface

interface skvt_out_if;
  logic                                     valid;
  logic                                     ready;
  logic [1:0]                               status;
  logic                                     cursor_on;
  logic signed [skvt_pkg::KEY_BITS-1:0]     cur_key;
  logic [skvt_pkg::DATUM_BITS-1:0]          cur_datum;
  logic [4:0]                               entry_count;

  modport source (output valid, output status, output cursor_on, output cur_key,
                  output cur_datum, output entry_count, input ready);
  modport sink   (input valid, input status, input cursor_on, input cur_key,
                  input cur_datum, input entry_count, output ready);
endinterface

@@ design/skvt_ram.sv @@
// skvt_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module skvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/skvt_ctrl.sv @@
// skvt_ctrl: request sequencer of the sorted key/value table
// depends on skvt_pkg for states, commands and status
module skvt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  skvt_pkg::stat_t stat,
  output skvt_pkg::cmd_t  cmd
);

  skvt_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= skvt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      skvt_pkg::S_IDLE: begin
        if (in_valid) state_nxt = skvt_pkg::S_SCAN;
      end
      skvt_pkg::S_SCAN: begin
        if (stat.scan_done) begin
          if (stat.is_insert && stat.hit) state_nxt = skvt_pkg::S_WRITE;
          else if (stat.is_insert && !stat.full) state_nxt = skvt_pkg::S_SHIFT_UP;
          else if (stat.is_remove && stat.hit) state_nxt = skvt_pkg::S_SHIFT_DN;
          else state_nxt = skvt_pkg::S_UPDATE;
        end
      end
      skvt_pkg::S_SHIFT_UP: begin
        if (stat.shift_done) state_nxt = skvt_pkg::S_WRITE;
      end
      skvt_pkg::S_SHIFT_DN: begin
        if (stat.shift_done) state_nxt = skvt_pkg::S_UPDATE;
      end
      skvt_pkg::S_WRITE:  state_nxt = skvt_pkg::S_UPDATE;
      skvt_pkg::S_UPDATE: state_nxt = skvt_pkg::S_FETCH;
      skvt_pkg::S_FETCH:  state_nxt = skvt_pkg::S_LOAD;
      skvt_pkg::S_LOAD: begin
        if (stat.out_free) state_nxt = skvt_pkg::S_IDLE;
      end
      default: state_nxt = skvt_pkg::S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    case (state_r)
      skvt_pkg::S_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.load_req = in_valid;
      end
      skvt_pkg::S_SCAN:     cmd.scan      = 1'b1;
      skvt_pkg::S_SHIFT_UP: cmd.shift_up  = 1'b1;
      skvt_pkg::S_SHIFT_DN: cmd.shift_dn  = 1'b1;
      skvt_pkg::S_WRITE:    cmd.write_new = 1'b1;
      skvt_pkg::S_UPDATE:   cmd.update    = 1'b1;
      skvt_pkg::S_FETCH:    cmd.fetch     = 1'b1;
      skvt_pkg::S_LOAD:     cmd.load_out  = stat.out_free;
      default:              cmd           = '0;
    endcase
  end

endmodule

@@ design/skvt_dpath.sv @@
// skvt_dpath: entry memory, scan and shift pointers, cursor, count and reply register
// depends on skvt_pkg and skvt_ram
module skvt_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  skvt_pkg::cmd_t                      cmd,
  output skvt_pkg::stat_t                     stat,
  input  logic [2:0]                          in_req_type,
  input  logic signed [skvt_pkg::KEY_BITS-1:0] in_req_key,
  input  logic [skvt_pkg::DATUM_BITS-1:0]     in_req_datum,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_status,
  output logic                                out_cursor_on,
  output logic signed [skvt_pkg::KEY_BITS-1:0] out_cur_key,
  output logic [skvt_pkg::DATUM_BITS-1:0]     out_cur_datum,
  output logic [4:0]                          out_entry_count
);

  localparam int IW = skvt_pkg::IDX_W;
  localparam int CW = skvt_pkg::CNT_W;
  localparam int KB = skvt_pkg::KEY_BITS;
  localparam int DB = skvt_pkg::DATUM_BITS;
  localparam logic [CW-1:0] FULL_CNT = CW'(skvt_pkg::DEPTH);

  // request registers
  logic [2:0]            req_type_r, req_type_nxt;
  logic signed [KB-1:0]  req_key_r, req_key_nxt;
  logic [DB-1:0]         req_datum_r, req_datum_nxt;

  // scan and shift state
  logic [CW-1:0]         idx_r, idx_nxt;
  logic                  rvalid_r, rvalid_nxt;
  logic [IW-1:0]         cmp_idx_r, cmp_idx_nxt;
  logic                  found_r, found_nxt;
  logic [CW-1:0]         pos_r, pos_nxt;
  logic                  hit_r, hit_nxt;
  logic [CW-1:0]         sp_r, sp_nxt;
  logic                  pend_r, pend_nxt;
  logic [IW-1:0]         wa_r, wa_nxt;

  // table state
  logic [CW-1:0]         count_r, count_nxt;
  logic [IW-1:0]         cur_pos_r, cur_pos_nxt;
  logic                  cur_valid_r, cur_valid_nxt;
  logic [1:0]            status_r, status_nxt;

  // reply register
  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            o_status_r, o_status_nxt;
  logic                  o_on_r, o_on_nxt;
  logic signed [KB-1:0]  o_key_r, o_key_nxt;
  logic [DB-1:0]         o_datum_r, o_datum_nxt;
  logic [CW-1:0]         o_count_r, o_count_nxt;

  // memory ports
  logic                        wr_en, rd_en;
  logic [IW-1:0]               wr_addr, rd_addr;
  logic [skvt_pkg::ENTRY_W-1:0] wr_data, rd_data;
  logic signed [KB-1:0]        rd_key;
  logic [DB-1:0]               rd_datum;

  logic                  searching;
  logic [CW-1:0]         scan_limit;
  logic                  scan_done, shift_done;
  logic [CW-1:0]         sp_m1, cur_p1;
  logic                  out_free;

  skvt_ram #(
    .WIDTH (skvt_pkg::ENTRY_W),
    .DEPTH (skvt_pkg::DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_key   = rd_data[skvt_pkg::ENTRY_W-1:DB];
  assign rd_datum = rd_data[DB-1:0];

  // scan covers the held entries only for keyed requests
  assign searching  = (req_type_r == skvt_pkg::REQ_INSERT) ||
                      (req_type_r == skvt_pkg::REQ_REMOVE) ||
                      (req_type_r == skvt_pkg::REQ_FIND);
  assign scan_limit = searching ? count_r : '0;
  assign scan_done  = ((idx_r == scan_limit) || found_r) && !rvalid_r;
  assign sp_m1      = sp_r - CW'(1);
  assign cur_p1     = CW'(cur_pos_r) + CW'(1);
  assign shift_done = cmd.shift_up ? ((sp_r == pos_r) && !pend_r)
                                   : ((sp_r >= count_r) && !pend_r);
  assign out_free   = !out_valid_r || out_ready;

  // status to the controller
  always_comb begin
    stat.scan_done  = scan_done;
    stat.shift_done = shift_done;
    stat.is_insert  = (req_type_r == skvt_pkg::REQ_INSERT);
    stat.is_remove  = (req_type_r == skvt_pkg::REQ_REMOVE);
    stat.hit        = hit_r;
    stat.full       = (count_r == FULL_CNT);
    stat.out_free   = out_free;
  end

  // datapath next values
  always_comb begin
    req_type_nxt  = req_type_r;
    req_key_nxt   = req_key_r;
    req_datum_nxt = req_datum_r;
    idx_nxt       = idx_r;
    rvalid_nxt    = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    found_nxt     = found_r;
    pos_nxt       = pos_r;
    hit_nxt       = hit_r;
    sp_nxt        = sp_r;
    pend_nxt      = 1'b0;
    wa_nxt        = wa_r;
    count_nxt     = count_r;
    cur_pos_nxt   = cur_pos_r;
    cur_valid_nxt = cur_valid_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_ready;
    o_status_nxt  = o_status_r;
    o_on_nxt      = o_on_r;
    o_key_nxt     = o_key_r;
    o_datum_nxt   = o_datum_r;
    o_count_nxt   = o_count_r;
    wr_en         = 1'b0;
    wr_addr       = wa_r;
    wr_data       = rd_data;
    rd_en         = 1'b0;
    rd_addr       = idx_r[IW-1:0];

    // capture request and arm the scan
    if (cmd.load_req) begin
      req_type_nxt  = in_req_type;
      req_key_nxt   = in_req_key;
      req_datum_nxt = in_req_datum;
      idx_nxt       = '0;
      found_nxt     = 1'b0;
      pos_nxt       = count_r;
      hit_nxt       = 1'b0;
    end

    // lower-bound scan, one read issued and one compare per cycle
    if (cmd.scan) begin
      if ((idx_r < scan_limit) && !found_r) begin
        rd_en       = 1'b1;
        rd_addr     = idx_r[IW-1:0];
        rvalid_nxt  = 1'b1;
        cmp_idx_nxt = idx_r[IW-1:0];
        idx_nxt     = idx_r + CW'(1);
      end
      if (rvalid_r && !found_r && (rd_key >= req_key_r)) begin
        found_nxt = 1'b1;
        pos_nxt   = CW'(cmp_idx_r);
        hit_nxt   = (rd_key == req_key_r);
      end
      // preload the shift pointer for either direction
      if (scan_done) begin
        sp_nxt = (req_type_r == skvt_pkg::REQ_INSERT) ? count_r : pos_r + CW'(1);
      end
    end

    // open a gap at pos: move entries up from the top
    if (cmd.shift_up) begin
      if (sp_r > pos_r) begin
        rd_en    = 1'b1;
        rd_addr  = sp_m1[IW-1:0];
        pend_nxt = 1'b1;
        wa_nxt   = sp_r[IW-1:0];
        sp_nxt   = sp_m1;
      end
      if (pend_r) begin
        wr_en = 1'b1;
      end
    end

    // close the gap at pos: move entries down from above
    if (cmd.shift_dn) begin
      if (sp_r < count_r) begin
        rd_en    = 1'b1;
        rd_addr  = sp_r[IW-1:0];
        pend_nxt = 1'b1;
        wa_nxt   = sp_m1[IW-1:0];
        sp_nxt   = sp_r + CW'(1);
      end
      if (pend_r) begin
        wr_en = 1'b1;
      end
    end

    // store the new or overwritten entry
    if (cmd.write_new) begin
      wr_en   = 1'b1;
      wr_addr = pos_r[IW-1:0];
      wr_data = {req_key_r, req_datum_r};
    end

    // count, cursor and status per request kind
    if (cmd.update) begin
      status_nxt = skvt_pkg::ST_OK;
      case (req_type_r)
        skvt_pkg::REQ_INSERT: begin
          if (!hit_r) begin
            if (count_r == FULL_CNT) status_nxt = skvt_pkg::ST_FULL;
            else count_nxt = count_r + CW'(1);
          end
          cur_valid_nxt = 1'b0;
        end
        skvt_pkg::REQ_REMOVE: begin
          if (hit_r) begin
            count_nxt = count_r - CW'(1);
            if (cur_valid_r) begin
              if (CW'(cur_pos_r) == pos_r) cur_valid_nxt = 1'b0;
              else if (CW'(cur_pos_r) > pos_r) cur_pos_nxt = cur_pos_r - IW'(1);
            end
          end else begin
            status_nxt = skvt_pkg::ST_NOT_FOUND;
          end
        end
        skvt_pkg::REQ_FIND: begin
          if (hit_r) begin
            cur_pos_nxt   = pos_r[IW-1:0];
            cur_valid_nxt = 1'b1;
          end else begin
            cur_valid_nxt = 1'b0;
            status_nxt    = skvt_pkg::ST_NOT_FOUND;
          end
        end
        skvt_pkg::REQ_FIRST: begin
          cur_pos_nxt   = '0;
          cur_valid_nxt = (count_r != '0);
        end
        skvt_pkg::REQ_STEP: begin
          if (!cur_valid_r) begin
            status_nxt = skvt_pkg::ST_CURSOR_OFF;
          end else if (cur_p1 >= count_r) begin
            cur_valid_nxt = 1'b0;
          end else begin
            cur_pos_nxt = cur_p1[IW-1:0];
          end
        end
        skvt_pkg::REQ_CLEAR: begin
          count_nxt     = '0;
          cur_valid_nxt = 1'b0;
        end
        default: ;
      endcase
      if (!cur_valid_nxt) cur_pos_nxt = '0;
    end

    // read the entry under the cursor
    if (cmd.fetch) begin
      rd_en   = 1'b1;
      rd_addr = cur_pos_r;
    end

    // load the reply register
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
      o_status_nxt  = status_r;
      o_on_nxt      = cur_valid_r;
      o_key_nxt     = cur_valid_r ? rd_key : '0;
      o_datum_nxt   = cur_valid_r ? rd_datum : '0;
      o_count_nxt   = count_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cur_pos_r   <= '0;
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      rvalid_r    <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      cur_pos_r   <= cur_pos_nxt;
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
      rvalid_r    <= rvalid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_type_r  <= req_type_nxt;
    req_key_r   <= req_key_nxt;
    req_datum_r <= req_datum_nxt;
    idx_r       <= idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    found_r     <= found_nxt;
    pos_r       <= pos_nxt;
    hit_r       <= hit_nxt;
    sp_r        <= sp_nxt;
    wa_r        <= wa_nxt;
    status_r    <= status_nxt;
    o_status_r  <= o_status_nxt;
    o_on_r      <= o_on_nxt;
    o_key_r     <= o_key_nxt;
    o_datum_r   <= o_datum_nxt;
    o_count_r   <= o_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = o_status_r;
  assign out_cursor_on   = o_on_r;
  assign out_cur_key     = o_key_r;
  assign out_cur_datum   = o_datum_r;
  assign out_entry_count = 5'(o_count_r);

endmodule

@@ design/sorted_key_value_table_unit.sv @@
// sorted_key_value_table_unit: top level of the sorted key/value table with cursor
// depends on skvt_pkg, skvt_if, skvt_ctrl and skvt_dpath
//
// Holds up to 16 key/datum entries in ascending signed-key order in a single
// registered-read RAM and answers each request with one reply (status, cursor
// entry, entry count). Requests are handled one at a time and the one RAM read
// per cycle sets the time: a lower-bound scan reads one entry per cycle and stops
// at the first key not below the request key, then insert or remove moves one
// entry per cycle, then come a write, the cursor and count update, a cursor read
// and the reply load. The next request is taken in the cycle after the reply load.
// A new request is taken while the previous reply still waits; it then holds at
// the reply load until that reply transfers.
module sorted_key_value_table_unit (
  input  logic        clk,
  input  logic        rst_n,
  skvt_in_if.sink     in_ch,
  skvt_out_if.source  out_ch
);

  skvt_pkg::cmd_t  cmd;
  skvt_pkg::stat_t stat;

  assign in_ch.ready = cmd.in_ready;

  // sequencer
  skvt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage and arithmetic
  skvt_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_req_type     (in_ch.req_type),
    .in_req_key      (in_ch.req_key),
    .in_req_datum    (in_ch.req_datum),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_cursor_on   (out_ch.cursor_on),
    .out_cur_key     (out_ch.cur_key),
    .out_cur_datum   (out_ch.cur_datum),
    .out_entry_count (out_ch.entry_count)
  );

endmodule

@@ tb/skvt_reply_checker.sv @@
// skvt_reply_checker: watches request and reply transfers of the sorted key/value table,
// keeps its own copy of the table and cursor, and compares every reply in order
// depends on skvt_pkg for widths, request kinds and status codes
module skvt_reply_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic [2:0]                           in_req_type,
  input  logic signed [skvt_pkg::KEY_BITS-1:0] in_req_key,
  input  logic [skvt_pkg::DATUM_BITS-1:0]      in_req_datum,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic [1:0]                           out_status,
  input  logic                                 out_cursor_on,
  input  logic signed [skvt_pkg::KEY_BITS-1:0] out_cur_key,
  input  logic [skvt_pkg::DATUM_BITS-1:0]      out_cur_datum,
  input  logic [4:0]                           out_entry_count,
  output int                                   fail_count,
  output int                                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    skvt_pkg::status_t                    status;
    logic                                 cursor_on;
    logic signed [skvt_pkg::KEY_BITS-1:0] cur_key;
    logic [skvt_pkg::DATUM_BITS-1:0]      cur_datum;
    logic [4:0]                           entry_count;
  } reply_t;

  // shadow table, kept sorted by signed key
  logic signed [skvt_pkg::KEY_BITS-1:0] shadow_key   [skvt_pkg::DEPTH];
  logic [skvt_pkg::DATUM_BITS-1:0]      shadow_datum [skvt_pkg::DEPTH];
  int                                   shadow_count;
  int                                   shadow_cursor;
  bit                                   shadow_cursor_on;

  reply_t reply_q[$];
  int     reply_no;

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("%0t ns: reply %0d field %s got %h want %h", $time, reply_no, field, got, want);
    fail_count++;
  endtask

  // apply one request to the shadow table and form the reply it should give
  task automatic apply_request(input logic [2:0] kind,
                               input logic signed [skvt_pkg::KEY_BITS-1:0] key,
                               input logic [skvt_pkg::DATUM_BITS-1:0] datum,
                               output reply_t r);
    int                pos;
    int                i;
    bit                hit;
    skvt_pkg::status_t st;
    pos = 0;
    st  = skvt_pkg::ST_OK;
    while (pos < shadow_count && shadow_key[pos] < key) pos++;
    hit = (pos < shadow_count) && (shadow_key[pos] == key);
    case (kind)
      skvt_pkg::REQ_INSERT: begin
        if (hit) begin
          shadow_datum[pos] = datum;
        end else if (shadow_count >= skvt_pkg::DEPTH) begin
          st = skvt_pkg::ST_FULL;
        end else begin
          for (i = shadow_count; i > pos; i--) begin
            shadow_key[i]   = shadow_key[i-1];
            shadow_datum[i] = shadow_datum[i-1];
          end
          shadow_key[pos]   = key;
          shadow_datum[pos] = datum;
          shadow_count++;
        end
        shadow_cursor_on = 1'b0;
      end
      skvt_pkg::REQ_REMOVE: begin
        if (hit) begin
          for (i = pos; i + 1 < shadow_count; i++) begin
            shadow_key[i]   = shadow_key[i+1];
            shadow_datum[i] = shadow_datum[i+1];
          end
          shadow_count--;
          if (shadow_cursor_on) begin
            if (shadow_cursor == pos) shadow_cursor_on = 1'b0;
            else if (shadow_cursor > pos) shadow_cursor--;
          end
        end else begin
          st = skvt_pkg::ST_NOT_FOUND;
        end
      end
      skvt_pkg::REQ_FIND: begin
        if (hit) begin
          shadow_cursor    = pos;
          shadow_cursor_on = 1'b1;
        end else begin
          shadow_cursor_on = 1'b0;
          st = skvt_pkg::ST_NOT_FOUND;
        end
      end
      skvt_pkg::REQ_FIRST: begin
        shadow_cursor    = 0;
        shadow_cursor_on = shadow_count > 0;
      end
      skvt_pkg::REQ_STEP: begin
        if (!shadow_cursor_on) begin
          st = skvt_pkg::ST_CURSOR_OFF;
        end else begin
          shadow_cursor++;
          if (shadow_cursor >= shadow_count) shadow_cursor_on = 1'b0;
        end
      end
      skvt_pkg::REQ_CLEAR: begin
        shadow_count     = 0;
        shadow_cursor_on = 1'b0;
      end
      default: ;
    endcase
    if (!shadow_cursor_on) shadow_cursor = 0;
    r.status      = st;
    r.cursor_on   = shadow_cursor_on;
    r.cur_key     = shadow_cursor_on ? shadow_key[shadow_cursor] : '0;
    r.cur_datum   = shadow_cursor_on ? shadow_datum[shadow_cursor] : '0;
    r.entry_count = 5'(shadow_count);
  endtask

  // compare replies first, then predict from the request of the same edge
  always @(posedge clk) begin
    reply_t want;
    reply_t fresh;
    if (!rst_n) begin
      shadow_count     = 0;
      shadow_cursor    = 0;
      shadow_cursor_on = 1'b0;
      reply_q.delete();
      pending = 0;
    end else begin
      if (out_valid && out_ready) begin
        reply_no++;
        if (reply_q.size() == 0) begin
          report("unrequested", 32'd1, 32'd0);
        end else begin
          want = reply_q.pop_front();
          if (out_status !== want.status)
            report("status", 32'(out_status), 32'(want.status));
          if (out_cursor_on !== want.cursor_on)
            report("cursor_on", 32'(out_cursor_on), 32'(want.cursor_on));
          if (out_cur_key !== want.cur_key)
            report("cur_key", out_cur_key, want.cur_key);
          if (out_cur_datum !== want.cur_datum)
            report("cur_datum", out_cur_datum, want.cur_datum);
          if (out_entry_count !== want.entry_count)
            report("entry_count", 32'(out_entry_count), 32'(want.entry_count));
        end
      end
      if (in_valid && in_ready) begin
        apply_request(in_req_type, in_req_key, in_req_datum, fresh);
        reply_q.push_back(fresh);
      end
      pending = reply_q.size();
    end
  end

endmodule

@@ tb/tb_sorted_key_value_table_unit.sv @@
// tb_sorted_key_value_table_unit: clock, reset, request stimulus and reply back-pressure
// for sorted_key_value_table_unit; checking is done by skvt_reply_checker
// depends on skvt_pkg, skvt_if, the block and tb/skvt_reply_checker.sv
module tb_sorted_key_value_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REQ_SPARE_A = 3'd6;
  localparam logic [2:0] REQ_SPARE_B = 3'd7;
  localparam int RANDOM_REQS = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int POOL_SIZE = 24;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  bit   steady;
  int   hold_asks;

  logic signed [skvt_pkg::KEY_BITS-1:0] key_pool [POOL_SIZE];

  skvt_in_if  req_ch ();
  skvt_out_if rsp_ch ();

  sorted_key_value_table_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  skvt_reply_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (req_ch.valid),
    .in_ready        (req_ch.ready),
    .in_req_type     (req_ch.req_type),
    .in_req_key      (req_ch.req_key),
    .in_req_datum    (req_ch.req_datum),
    .out_valid       (rsp_ch.valid),
    .out_ready       (rsp_ch.ready),
    .out_status      (rsp_ch.status),
    .out_cursor_on   (rsp_ch.cursor_on),
    .out_cur_key     (rsp_ch.cur_key),
    .out_cur_datum   (rsp_ch.cur_datum),
    .out_entry_count (rsp_ch.entry_count),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("sorted_key_value_table_unit: mismatch");
    $finish;
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 45);
  endfunction

  // reply side back-pressure, with an occasional long hold-off
  initial begin
    int stall;
    int holds_seen;
    holds_seen   = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != holds_seen) begin
        holds_seen = hold_asks;
        stall = HOLD_CYCLES;
      end else begin
        stall = pick_gap();
      end
      if (stall == 0) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  // one request transfer; entered and left at a falling edge
  task automatic send_req(input logic [2:0] kind,
                          input logic signed [skvt_pkg::KEY_BITS-1:0] key,
                          input logic [skvt_pkg::DATUM_BITS-1:0] datum);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= kind;
    req_ch.req_key   <= key;
    req_ch.req_datum <= datum;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // random request: keys mostly from a small pool so the table fills and hits
  task automatic send_random_req(output bit counted);
    int                                   r;
    logic [2:0]                           kind;
    logic signed [skvt_pkg::KEY_BITS-1:0] key;
    r = $urandom_range(0, 99);
    if (r < 32)      kind = skvt_pkg::REQ_INSERT;
    else if (r < 47) kind = skvt_pkg::REQ_REMOVE;
    else if (r < 62) kind = skvt_pkg::REQ_FIND;
    else if (r < 72) kind = skvt_pkg::REQ_FIRST;
    else if (r < 95) kind = skvt_pkg::REQ_STEP;
    else if (r < 98) kind = skvt_pkg::REQ_CLEAR;
    else kind = $urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B;
    if ($urandom_range(0, 9) < 8) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    else key = $urandom;
    send_req(kind, key, $urandom);
    counted = (kind != REQ_SPARE_A) && (kind != REQ_SPARE_B);
  endtask

  // stimulus and verdict
  initial begin
    int  done;
    int  i;
    bit  counted;
    rst_n            = 1'b0;
    steady           = 1'b0;
    hold_asks        = 0;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = skvt_pkg::REQ_INSERT;
    req_ch.req_key   = '0;
    req_ch.req_datum = '0;
    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7fff_ffff;
    key_pool[2] = 32'sh0000_0000;
    key_pool[3] = -32'sd1;
    for (i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table corner cases
    send_req(skvt_pkg::REQ_STEP, 32'sd0, 32'h0);
    send_req(skvt_pkg::REQ_FIRST, 32'sd0, 32'h0);
    send_req(skvt_pkg::REQ_FIND, 32'sd5, 32'h0);
    send_req(skvt_pkg::REQ_REMOVE, 32'sd5, 32'h0);
    send_req(skvt_pkg::REQ_CLEAR, 32'sd0, 32'h0);
    // key and datum extremes, then overwrite of an existing key
    send_req(skvt_pkg::REQ_INSERT, 32'sh7fff_ffff, 32'hffff_ffff);
    send_req(skvt_pkg::REQ_INSERT, 32'sh8000_0000, 32'h0000_0000);
    send_req(skvt_pkg::REQ_INSERT, 32'sd0, 32'ha5a5_a5a5);
    send_req(skvt_pkg::REQ_INSERT, -32'sd1, 32'h5a5a_5a5a);
    send_req(skvt_pkg::REQ_INSERT, 32'sd0, 32'h1234_5678);
    // walk the cursor off the end
    send_req(skvt_pkg::REQ_FIRST, 32'sd0, 32'h0);
    repeat (4) send_req(skvt_pkg::REQ_STEP, 32'sd0, 32'h0);
    // remove below the cursor, then the entry under it
    send_req(skvt_pkg::REQ_FIND, 32'sd0, 32'h0);
    send_req(skvt_pkg::REQ_REMOVE, -32'sd1, 32'h0);
    send_req(skvt_pkg::REQ_REMOVE, 32'sd0, 32'h0);
    send_req(skvt_pkg::REQ_FIND, 32'sh7fff_ffff, 32'h0);
    send_req(REQ_SPARE_A, 32'sd0, 32'h0);
    send_req(REQ_SPARE_B, 32'sd0, 32'h0);
    // fill up, insert into the full table, overwrite while full
    for (i = 0; i < skvt_pkg::DEPTH - 2; i++)
      send_req(skvt_pkg::REQ_INSERT, 32'sd100 + i, $urandom);
    send_req(skvt_pkg::REQ_INSERT, 32'sd200, 32'hdead_beef);
    send_req(skvt_pkg::REQ_INSERT, 32'sd100, 32'hfeed_f00d);
    send_req(skvt_pkg::REQ_CLEAR, 32'sd0, 32'h0);
    send_req(skvt_pkg::REQ_CLEAR, 32'sd0, 32'h0);

    // random traffic; long reply hold-offs early and midway fill the block
    hold_asks++;
    done = 0;
    while (done < RANDOM_REQS) begin
      if (done % 150 == 0) steady = ($urandom_range(0, 3) == 0);
      if (done == RANDOM_REQS / 2) hold_asks++;
      send_random_req(counted);
      if (counted) done++;
    end
    req_ch.valid <= 1'b0;

    // drain
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("sorted_key_value_table_unit: match");
    end else begin
      $display("sorted_key_value_table_unit: mismatch");
    end
    $finish;
  end

endmodule

@@ sorted_key_value_table_unit.f @@
design/skvt_pkg.sv
design/skvt_if.sv
design/skvt_ram.sv
design/skvt_ctrl.sv
design/skvt_dpath.sv
design/sorted_key_value_table_unit.sv
tb/skvt_reply_checker.sv
tb/tb_sorted_key_value_table_unit.sv
